>>> design/crrt_pkg.sv
`timescale 1ns / 1ps

package crrt_pkg;

   // Field widths of the request, result and table entry
   localparam int ADDR_BITS = 48;
   localparam int SIZE_BITS = 32;
   localparam int REF_BITS  = 16;
   localparam int PROT_BITS = 4;

   // Default table depth
   localparam int ENTRIES = 64;

   // Bump pointer value after reset, page rounding mask
   localparam logic [ADDR_BITS-1:0] HEAP_BASE_RESET = ADDR_BITS'(32'h1000_0000);
   localparam logic [SIZE_BITS:0]   PAGE_MASK       = (SIZE_BITS+1)'(12'hFFF);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [REF_BITS-1:0]  ref_type;
   typedef logic [PROT_BITS-1:0] prot_type;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_SHARE    = 2'd1,
      CMD_WRITABLE = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PRIVATE   = 3'd2,
      ST_COPIED    = 3'd3,
      ST_IN_PLACE  = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type  cmd;
      addr_type vaddr;
      size_type size;
      prot_type prot;
   } req_type;

   typedef struct packed {
      addr_type   addr;
      ref_type    refcount;
      status_type status;
   } rsp_type;

   typedef struct packed {
      addr_type base;
      size_type size;
      prot_type prot;
      ref_type  refs;
   } entry_type;

endpackage

>>> design/crrt_mem.sv
`timescale 1ns / 1ps

module crrt_mem #(
   parameter int ENTRIES = crrt_pkg::ENTRIES
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  crrt_pkg::entry_type        wr_data,
   input  logic [$clog2(ENTRIES)-1:0] rd_idx,
   output crrt_pkg::entry_type        rd_data
);

   crrt_pkg::entry_type mem [ENTRIES];
   crrt_pkg::entry_type rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/crrt_cmp.sv
`timescale 1ns / 1ps

module crrt_cmp (
   input  crrt_pkg::cmd_type   cmd,
   input  crrt_pkg::addr_type  vaddr,
   input  crrt_pkg::entry_type entry,
   output logic                hit
);

   crrt_pkg::addr_type offset;
   logic               exact;
   logic               contains;

   // Exact base match, or address inside [base, base + size)
   always_comb begin
      offset   = vaddr - entry.base;
      exact    = (vaddr == entry.base);
      contains = (vaddr >= entry.base) && (offset < crrt_pkg::addr_type'(entry.size));
      hit      = (cmd == crrt_pkg::CMD_WRITABLE) ? contains : exact;
   end

endmodule

>>> design/cow_region_refcount_table.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake            Payload
// request    in         start / busy         req_data  (crrt_pkg::req_type)
// result     out        rsp_valid strobe     rsp_data  (crrt_pkg::rsp_type)
// csr        in         csr_valid/csr_ready  csr_wdata (heap base, loads bump pointer)
//
// Allocate finishes in the accept cycle; its result strobes on the next cycle.
// Share, make writable and query walk the entry memory one entry per cycle
// through its single registered read port; make writable may append a private copy.
// Reset clears the entry count and loads the bump pointer; entries need no clearing.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module cow_region_refcount_table #(
   parameter int ENTRIES = crrt_pkg::ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  crrt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output crrt_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  crrt_pkg::addr_type   csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_APPEND
   } state_type;

   state_type           state_ff,    state_in;
   crrt_pkg::req_type   req_ff,      req_in;
   logic [CNT_W-1:0]    count_ff,    count_in;
   crrt_pkg::addr_type  bump_ff,     bump_in;
   logic [CNT_W-1:0]    scan_ff,     scan_in;
   logic                dvld_ff,     dvld_in;
   logic [IDX_W-1:0]    didx_ff,     didx_in;
   logic [IDX_W-1:0]    hit_idx_ff,  hit_idx_in;
   crrt_pkg::entry_type ent_ff,      ent_in;
   crrt_pkg::rsp_type   rsp_ff,      rsp_in;
   logic                rsp_vld_ff,  rsp_vld_in;

   logic                accept;
   logic                room;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   crrt_pkg::entry_type wr_data;
   crrt_pkg::entry_type rd_data;
   logic                hit;
   logic [crrt_pkg::SIZE_BITS:0] round_size;
   crrt_pkg::addr_type  alloc_addr;
   crrt_pkg::ref_type   new_refs;

   // Entry storage
   crrt_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Shared compare unit, one entry per cycle
   crrt_cmp u_cmp (
      .cmd   (req_ff.cmd),
      .vaddr (req_ff.vaddr),
      .entry (rd_data),
      .hit   (hit)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign accept    = start && !busy;
   assign room      = (count_ff < FULL_CNT);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Sequence one transaction
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      count_in   = count_ff;
      bump_in    = bump_ff;
      scan_in    = scan_ff;
      dvld_in    = 1'b0;
      didx_in    = didx_ff;
      hit_idx_in = hit_idx_ff;
      ent_in     = ent_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = count_ff[IDX_W-1:0];
      wr_data    = ent_ff;
      new_refs   = ent_ff.refs;

      round_size = ({1'b0, req_data.size} + crrt_pkg::PAGE_MASK) & ~crrt_pkg::PAGE_MASK;
      alloc_addr = (req_data.vaddr == '0) ? bump_ff : req_data.vaddr;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               bump_in = csr_wdata;
            end
            if (accept) begin
               req_in  = req_data;
               scan_in = '0;
               if (req_data.cmd == crrt_pkg::CMD_ALLOC) begin
                  // Allocate: take address, append if room, answer next cycle
                  if (req_data.vaddr == '0) begin
                     bump_in = bump_ff + crrt_pkg::addr_type'(round_size);
                  end
                  rsp_vld_in    = 1'b1;
                  rsp_in.addr   = alloc_addr;
                  if (room) begin
                     wr_en         = 1'b1;
                     wr_data.base  = alloc_addr;
                     wr_data.size  = req_data.size;
                     wr_data.prot  = req_data.prot;
                     wr_data.refs  = crrt_pkg::ref_type'(1);
                     count_in      = count_ff + 1'b1;
                     rsp_in.refcount = crrt_pkg::ref_type'(1);
                     rsp_in.status = crrt_pkg::ST_OK;
                  end else begin
                     rsp_in.refcount = '0;
                     rsp_in.status = crrt_pkg::ST_FULL;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (dvld_ff && hit) begin
               // First hit: hold the entry for the update step
               ent_in     = rd_data;
               hit_idx_in = didx_ff;
               state_in   = S_UPDATE;
            end else if (scan_ff < count_ff) begin
               // Issue the next read
               dvld_in = 1'b1;
               didx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end else if (!dvld_ff) begin
               // Nothing left in flight: no match
               rsp_vld_in      = 1'b1;
               rsp_in.addr     = '0;
               rsp_in.refcount = '0;
               rsp_in.status   = crrt_pkg::ST_NOT_FOUND;
               state_in        = S_IDLE;
            end
         end

         S_UPDATE: begin
            rsp_vld_in  = 1'b1;
            rsp_in.addr = ent_ff.base;
            wr_idx      = hit_idx_ff;
            state_in    = S_IDLE;
            case (req_ff.cmd)
               crrt_pkg::CMD_SHARE: begin
                  if (ent_ff.size >= req_ff.size) begin
                     if (ent_ff.refs != '1) begin
                        new_refs = ent_ff.refs + 1'b1;
                     end
                     wr_en         = 1'b1;
                     wr_data.refs  = new_refs;
                     rsp_in.status = crrt_pkg::ST_OK;
                  end else begin
                     rsp_in.status = crrt_pkg::ST_NOT_FOUND;
                  end
                  rsp_in.refcount = new_refs;
               end
               crrt_pkg::CMD_WRITABLE: begin
                  if (ent_ff.refs <= crrt_pkg::ref_type'(1)) begin
                     rsp_in.refcount = ent_ff.refs;
                     rsp_in.status   = crrt_pkg::ST_PRIVATE;
                  end else begin
                     wr_en           = 1'b1;
                     rsp_in.refcount = crrt_pkg::ref_type'(1);
                     if (room) begin
                        // Drop one owner, then append the private copy
                        wr_data.refs  = ent_ff.refs - 1'b1;
                        rsp_in.status = crrt_pkg::ST_COPIED;
                        state_in      = S_APPEND;
                     end else begin
                        wr_data.refs  = crrt_pkg::ref_type'(1);
                        rsp_in.status = crrt_pkg::ST_IN_PLACE;
                     end
                  end
               end
               default: begin
                  rsp_in.refcount = ent_ff.refs;
                  rsp_in.status   = crrt_pkg::ST_OK;
               end
            endcase
         end

         S_APPEND: begin
            wr_en        = 1'b1;
            wr_data.refs = crrt_pkg::ref_type'(1);
            count_in     = count_ff + 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      didx_ff    <= didx_in;
      hit_idx_ff <= hit_idx_in;
      ent_ff     <= ent_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         bump_ff    <= crrt_pkg::HEAP_BASE_RESET;
         dvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         bump_ff    <= bump_in;
         dvld_ff    <= dvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Entry count stays within the table
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("entry count beyond table depth");

   // A full table never reports owners
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.status == crrt_pkg::ST_FULL) |-> (rsp_ff.refcount == '0))
      else $error("table full result with nonzero refcount");

   // A lookup command starts a scan on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.cmd != crrt_pkg::CMD_ALLOC) |=> (state_ff == S_SCAN))
      else $error("lookup did not start a scan");

   // The scan pointer never runs past the filled entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= count_ff))
      else $error("scan pointer past entry count");

endmodule
